### hw/rtl/chs_pkg.sv
`timescale 1ns / 1ps

package chs_pkg;

	localparam int unsigned KEY_W = 31;
	localparam int unsigned KICKS_W = 7;
	localparam int unsigned STATUS_W = 3;
	localparam logic [KICKS_W-1:0] KICKS_RESET = 7'd24;
	localparam logic [KICKS_W-1:0] KICKS_CAP = 7'd64;

	typedef enum logic [STATUS_W-1:0] {
		STAT_HIT      = 3'd0,
		STAT_MISS     = 3'd1,
		STAT_INSERTED = 3'd2,
		STAT_PRESENT  = 3'd3,
		STAT_FAILED   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		LEFT_ZERO,
		LEFT_CUR,
		LEFT_EVICT
	} left_sel_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_LRD,
		ST_LCHK,
		ST_RD1,
		ST_CHK1,
		ST_RD2,
		ST_CHK2,
		ST_RESP
	} chs_state_t;

	typedef struct packed {
		logic      load;
		logic      clr_step;
		logic      rd_lookup;
		logic      rd1;
		logic      rd2;
		logic      chk1;
		logic      chk2;
		logic      res_load;
		status_t   res_code;
		left_sel_t res_sel;
		logic      out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic div_done;
		logic op;
		logic hit;
		logic v1;
		logic v2;
		logic last_round;
		logic zero_rounds;
	} sts_t;

endpackage

### hw/rtl/chs_ram.sv
`timescale 1ns / 1ps

module chs_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/chs_div.sv
`timescale 1ns / 1ps

module chs_div #(
	parameter int unsigned TABLE_SIZE = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [chs_pkg::KEY_W-1:0]     key,
	output logic                          done,
	output logic [$clog2(TABLE_SIZE)-1:0] slot_one,
	output logic [$clog2(TABLE_SIZE)-1:0] slot_two
);
	import chs_pkg::*;

	localparam int unsigned SW = $clog2(TABLE_SIZE);
	localparam bit IS_POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;

	generate
		if (IS_POW2) begin : g_pow2
			logic          done_q;
			logic [SW-1:0] s1_q;
			logic [SW-1:0] s2_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					s1_q <= key[SW-1:0];
					s2_q <= key[2*SW-1:SW];
				end
			end

			assign done = done_q;
			assign slot_one = s1_q;
			assign slot_two = s2_q;
		end else begin : g_recip
			localparam int unsigned SH = KEY_W + SW;
			localparam int unsigned PW = 2 * KEY_W + 1;
			localparam logic [63:0] RECIP_FULL =
				((64'd1 << SH) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
			localparam logic [KEY_W:0] RECIP = (KEY_W + 1)'(RECIP_FULL);
			localparam logic [SW-1:0] N_SW = SW'(TABLE_SIZE);

			logic             busy_q;
			logic             done_q;
			logic [1:0]       phase_q;
			logic [KEY_W-1:0] key_q;
			logic [KEY_W-1:0] quo_q;
			logic [SW-1:0]    quo2_q;
			logic [SW-1:0]    r1_q;
			logic [SW-1:0]    r2_q;
			logic [KEY_W-1:0] mul_in;
			logic [PW-1:0]    prod;
			logic [KEY_W-1:0] quo_n;
			logic [SW-1:0]    r1_n;
			logic [SW-1:0]    r2_n;

			always_comb begin
				mul_in = (phase_q == 2'd0) ? key_q : quo_q;
				prod = {{(KEY_W + 1){1'b0}}, mul_in} * {{KEY_W{1'b0}}, RECIP};
				quo_n = KEY_W'(prod >> SH);
				r1_n = key_q[SW-1:0] - quo_q[SW-1:0] * N_SW;
				r2_n = quo_q[SW-1:0] - quo2_q * N_SW;
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					busy_q <= 1'b0;
					done_q <= 1'b0;
					phase_q <= '0;
				end else begin
					done_q <= busy_q && (phase_q == 2'd2);
					if (start) begin
						busy_q <= 1'b1;
						phase_q <= '0;
					end else if (busy_q) begin
						phase_q <= phase_q + 2'd1;
						if (phase_q == 2'd2) begin
							busy_q <= 1'b0;
						end
					end
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					key_q <= key;
				end
				if (busy_q) begin
					unique case (phase_q)
						2'd0: quo_q <= quo_n;
						2'd1: begin
							quo2_q <= quo_n[SW-1:0];
							r1_q <= r1_n;
						end
						default: r2_q <= r2_n;
					endcase
				end
			end

			assign done = done_q;
			assign slot_one = r1_q;
			assign slot_two = r2_q;
		end
	endgenerate

endmodule

### hw/rtl/chs_dp.sv
`timescale 1ns / 1ps

module chs_dp #(
	parameter int unsigned TABLE_SIZE = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  chs_pkg::cmd_t                cmd,
	output chs_pkg::sts_t                sts,
	input  logic                         operation,
	input  logic [chs_pkg::KEY_W-1:0]    key,
	input  logic                         cfg_we,
	input  logic [chs_pkg::KICKS_W-1:0]  cfg_wdata,
	output logic [chs_pkg::STATUS_W-1:0] status,
	output logic [chs_pkg::KEY_W-1:0]    leftover_key
);
	import chs_pkg::*;

	localparam int unsigned SW = $clog2(TABLE_SIZE);
	localparam int unsigned EW = 1 + KEY_W + SW;

	logic [KICKS_W-1:0]  max_kicks_q;
	logic [KICKS_W-1:0]  rounds_q;
	logic [KICKS_W-1:0]  kicks_cap;
	logic [SW-1:0]       clr_addr_q;
	logic                op_q;
	logic [KEY_W-1:0]    cur_key_q;
	logic [SW-1:0]       pos1_q;
	logic [SW-1:0]       pos2_q;
	status_t             res_status_q;
	logic [KEY_W-1:0]    res_left_q;
	logic [STATUS_W-1:0] status_q;
	logic [KEY_W-1:0]    leftover_q;

	logic                div_done;
	logic [SW-1:0]       div_s1;
	logic [SW-1:0]       div_s2;

	logic                we1;
	logic                we2;
	logic [SW-1:0]       waddr1;
	logic [SW-1:0]       waddr2;
	logic [EW-1:0]       wdata1;
	logic [EW-1:0]       wdata2;
	logic [EW-1:0]       rdata1;
	logic [EW-1:0]       rdata2;
	logic                v1;
	logic                v2;
	logic [KEY_W-1:0]    k1;
	logic [KEY_W-1:0]    k2;
	logic [SW-1:0]       o1;
	logic [SW-1:0]       o2;
	logic [KEY_W-1:0]    left_n;

	chs_div #(
		.TABLE_SIZE(TABLE_SIZE)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.load),
		.key     (key),
		.done    (div_done),
		.slot_one(div_s1),
		.slot_two(div_s2)
	);

	always_comb begin
		v1 = rdata1[EW-1];
		k1 = rdata1[EW-2:SW];
		o1 = rdata1[SW-1:0];
		v2 = rdata2[EW-1];
		k2 = rdata2[EW-2:SW];
		o2 = rdata2[SW-1:0];
		we1 = cmd.clr_step | cmd.chk1;
		we2 = cmd.clr_step | cmd.chk2;
		waddr1 = cmd.clr_step ? clr_addr_q : pos1_q;
		waddr2 = cmd.clr_step ? clr_addr_q : pos2_q;
		wdata1 = cmd.clr_step ? '0 : {1'b1, cur_key_q, pos2_q};
		wdata2 = cmd.clr_step ? '0 : {1'b1, cur_key_q, pos1_q};
		kicks_cap = (max_kicks_q > KICKS_CAP) ? KICKS_CAP : max_kicks_q;
		unique case (cmd.res_sel)
			LEFT_CUR:   left_n = cur_key_q;
			LEFT_EVICT: left_n = k2;
			default:    left_n = '0;
		endcase
	end

	chs_ram #(
		.WIDTH(EW),
		.DEPTH(TABLE_SIZE)
	) u_ram1 (
		.clk  (clk),
		.we   (we1),
		.waddr(waddr1),
		.wdata(wdata1),
		.re   (cmd.rd_lookup | cmd.rd1),
		.raddr(pos1_q),
		.rdata(rdata1)
	);

	chs_ram #(
		.WIDTH(EW),
		.DEPTH(TABLE_SIZE)
	) u_ram2 (
		.clk  (clk),
		.we   (we2),
		.waddr(waddr2),
		.wdata(wdata2),
		.re   (cmd.rd_lookup | cmd.rd2),
		.raddr(pos2_q),
		.rdata(rdata2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_kicks_q <= KICKS_RESET;
			clr_addr_q <= '0;
		end else begin
			if (cfg_we) begin
				max_kicks_q <= cfg_wdata;
			end
			if (cmd.clr_step) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= operation;
			cur_key_q <= key;
			rounds_q <= kicks_cap;
		end
		if (div_done) begin
			pos1_q <= div_s1;
			pos2_q <= div_s2;
		end
		if (cmd.chk1 && v1) begin
			cur_key_q <= k1;
			pos2_q <= o1;
		end
		if (cmd.chk2 && v2) begin
			cur_key_q <= k2;
			pos1_q <= o2;
			rounds_q <= rounds_q - 1'b1;
		end
		if (cmd.res_load) begin
			res_status_q <= cmd.res_code;
			res_left_q <= left_n;
		end
		if (cmd.out_load) begin
			status_q <= res_status_q;
			leftover_q <= res_left_q;
		end
	end

	always_comb begin
		sts.clr_last = clr_addr_q == SW'(TABLE_SIZE - 1);
		sts.div_done = div_done;
		sts.op = op_q;
		sts.hit = (v1 && k1 == cur_key_q) || (v2 && k2 == cur_key_q);
		sts.v1 = v1;
		sts.v2 = v2;
		sts.last_round = rounds_q == KICKS_W'(1);
		sts.zero_rounds = rounds_q == '0;
	end

	assign status = status_q;
	assign leftover_key = leftover_q;

endmodule

### hw/rtl/chs_ctrl.sv
`timescale 1ns / 1ps

module chs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  chs_pkg::sts_t  sts,
	output chs_pkg::cmd_t  cmd
);
	import chs_pkg::*;

	chs_state_t state_q;
	chs_state_t state_n;
	logic       out_valid_q;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_CLEAR: if (sts.clr_last) state_n = ST_IDLE;
			ST_IDLE:  if (in_valid) state_n = ST_DIV;
			ST_DIV:   if (sts.div_done) state_n = ST_LRD;
			ST_LRD:   state_n = ST_LCHK;
			ST_LCHK: begin
				if (!sts.op || sts.hit || sts.zero_rounds) begin
					state_n = ST_RESP;
				end else begin
					state_n = ST_CHK1;
				end
			end
			ST_RD1:   state_n = ST_CHK1;
			ST_CHK1:  state_n = sts.v1 ? ST_RD2 : ST_RESP;
			ST_RD2:   state_n = ST_CHK2;
			ST_CHK2: begin
				if (!sts.v2 || sts.last_round) begin
					state_n = ST_RESP;
				end else begin
					state_n = ST_RD1;
				end
			end
			ST_RESP:  if (!out_valid_q || out_ready) state_n = ST_IDLE;
			default:  state_n = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.res_code = STAT_HIT;
		cmd.res_sel = LEFT_ZERO;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: cmd.clr_step = 1'b1;
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_LRD:   cmd.rd_lookup = 1'b1;
			ST_LCHK: begin
				priority if (!sts.op) begin
					cmd.res_load = 1'b1;
					cmd.res_code = sts.hit ? STAT_HIT : STAT_MISS;
				end else if (sts.hit) begin
					cmd.res_load = 1'b1;
					cmd.res_code = STAT_PRESENT;
				end else if (sts.zero_rounds) begin
					cmd.res_load = 1'b1;
					cmd.res_code = STAT_FAILED;
					cmd.res_sel = LEFT_CUR;
				end else begin
					cmd.res_load = 1'b0;
				end
			end
			ST_RD1:   cmd.rd1 = 1'b1;
			ST_CHK1: begin
				cmd.chk1 = 1'b1;
				if (!sts.v1) begin
					cmd.res_load = 1'b1;
					cmd.res_code = STAT_INSERTED;
				end
			end
			ST_RD2:   cmd.rd2 = 1'b1;
			ST_CHK2: begin
				cmd.chk2 = 1'b1;
				priority if (!sts.v2) begin
					cmd.res_load = 1'b1;
					cmd.res_code = STAT_INSERTED;
				end else if (sts.last_round) begin
					cmd.res_load = 1'b1;
					cmd.res_code = STAT_FAILED;
					cmd.res_sel = LEFT_EVICT;
				end else begin
					cmd.res_load = 1'b0;
				end
			end
			ST_RESP:  cmd.out_load = !out_valid_q || out_ready;
			default:  cmd.load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_accept_drops_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready held after a request was accepted");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !out_valid_q || out_ready)
		else $error("pending result overwritten");

	a_chk1_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CHK1 |-> $past(state_q) == ST_LCHK || $past(state_q) == ST_RD1)
		else $error("table one checked without a read");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |=> state_q == ST_RESP)
		else $error("result stored outside the response path");

endmodule

### hw/rtl/cuckoo_hash_set.sv
// Two-table cuckoo hash set of 31-bit keys with one request in flight at a time.
// After reset both tables are swept clean, one slot per cycle, with in_ready low;
// max_kicks may be written meanwhile. Slots come from bit fields of the key when
// TABLE_SIZE is a power of two and from a reciprocal-multiply remainder unit
// otherwise. Each table is a one-port-write, registered-read RAM, so a lookup or
// an already-present insert passes from acceptance through the slot unit, a read
// of both tables and a check before its result reaches the output register and
// raises out_valid; an insert that lands in its table-one slot adds the table-one
// check and swap, which reuses that read, and every further displacement step
// (read, then check and swap in the other table) alternates between the tables.
// The next request can be accepted the cycle after the result enters the output
// register, where it sits while the next request is taken. A failed insert
// reports the homeless key in leftover_key.
`timescale 1ns / 1ps

module cuckoo_hash_set #(
	parameter int unsigned TABLE_SIZE = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         operation,
	input  logic [chs_pkg::KEY_W-1:0]    key,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [chs_pkg::STATUS_W-1:0] status,
	output logic [chs_pkg::KEY_W-1:0]    leftover_key,
	input  logic                         cfg_we,
	input  logic [chs_pkg::KICKS_W-1:0]  cfg_wdata
);
	import chs_pkg::*;

	cmd_t cmd;
	sts_t sts;

	chs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	chs_dp #(
		.TABLE_SIZE(TABLE_SIZE)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.operation   (operation),
		.key         (key),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.status      (status),
		.leftover_key(leftover_key)
	);

endmodule

### tb/sv/tb_cuckoo_hash_set.sv
`timescale 1ns / 1ps

module tb_cuckoo_hash_set;
	import chs_pkg::*;

	localparam int unsigned TABLE_SIZE = 16;

	typedef struct {
		logic             op;
		logic [KEY_W-1:0] k;
	} request_t;

	typedef struct {
		status_t          st;
		logic [KEY_W-1:0] left;
	} outcome_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                operation = 1'b0;
	logic [KEY_W-1:0]    key = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [KEY_W-1:0]    leftover_key;
	logic                cfg_we = 1'b0;
	logic [KICKS_W-1:0]  cfg_wdata = '0;

	logic [KEY_W-1:0]   row1_key [TABLE_SIZE];
	logic               row1_used [TABLE_SIZE];
	logic [KEY_W-1:0]   row2_key [TABLE_SIZE];
	logic               row2_used [TABLE_SIZE];
	logic [KICKS_W-1:0] kick_limit;

	request_t         request_q[$];
	outcome_t         awaited_outcomes[$];
	logic [KEY_W-1:0] key_pool[$];
	request_t         next_req;
	outcome_t         oldest;
	status_t          calc_st;
	logic [KEY_W-1:0] calc_left;
	int unsigned      send_idle = 15;
	int unsigned      recv_idle = 47;
	int unsigned      mismatches = 0;

	cuckoo_hash_set #(
		.TABLE_SIZE(TABLE_SIZE)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.key(key),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.leftover_key(leftover_key),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("cuckoo_hash_set verification failed");
		$finish;
	end

	function automatic int slot_one(input logic [KEY_W-1:0] k);
		return int'(k % TABLE_SIZE);
	endfunction

	function automatic int slot_two(input logic [KEY_W-1:0] k);
		return int'((k / TABLE_SIZE) % TABLE_SIZE);
	endfunction

	function automatic bit holds_key(input logic [KEY_W-1:0] k);
		return (row1_used[slot_one(k)] && row1_key[slot_one(k)] == k) ||
			(row2_used[slot_two(k)] && row2_key[slot_two(k)] == k);
	endfunction

	task automatic apply_to_tables(input logic op, input logic [KEY_W-1:0] k_in,
			output status_t st, output logic [KEY_W-1:0] left);
		logic [KEY_W-1:0] k;
		logic [KEY_W-1:0] tmp;
		int               p;
		int               rounds;
		bit               done;
		k = k_in;
		left = '0;
		done = 1'b0;
		if (holds_key(k)) begin
			st = op ? STAT_PRESENT : STAT_HIT;
		end else if (!op) begin
			st = STAT_MISS;
		end else begin
			rounds = (kick_limit > KICKS_CAP) ? int'(KICKS_CAP) : int'(kick_limit);
			st = STAT_FAILED;
			for (int i = 0; i < rounds && !done; i++) begin
				p = slot_one(k);
				if (!row1_used[p]) begin
					row1_key[p] = k;
					row1_used[p] = 1'b1;
					done = 1'b1;
				end else begin
					tmp = row1_key[p];
					row1_key[p] = k;
					k = tmp;
					p = slot_two(k);
					if (!row2_used[p]) begin
						row2_key[p] = k;
						row2_used[p] = 1'b1;
						done = 1'b1;
					end else begin
						tmp = row2_key[p];
						row2_key[p] = k;
						k = tmp;
					end
				end
			end
			if (done)
				st = STAT_INSERTED;
			else
				left = k;
		end
	endtask

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			operation <= 1'b0;
			key <= '0;
		end else if (!in_valid || in_ready) begin
			if (request_q.size() != 0 && $urandom_range(99) >= send_idle) begin
				next_req = request_q.pop_front();
				in_valid <= 1'b1;
				operation <= next_req.op;
				key <= next_req.k;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (awaited_outcomes.size() == 0) begin
					flag_mismatch("unrequested result", 32'(status), 32'(leftover_key));
				end else begin
					oldest = awaited_outcomes.pop_front();
					if (status !== oldest.st)
						flag_mismatch("status", 32'(status), 32'(oldest.st));
					if (leftover_key !== oldest.left)
						flag_mismatch("leftover_key", 32'(leftover_key), 32'(oldest.left));
				end
			end
			if (in_valid && in_ready) begin
				apply_to_tables(operation, key, calc_st, calc_left);
				awaited_outcomes.push_back('{calc_st, calc_left});
			end
		end
	end

	task automatic push_req(input logic op, input logic [KEY_W-1:0] k);
		request_q.push_back('{op, k});
		if (op) begin
			if (key_pool.size() < 48)
				key_pool.push_back(k);
			else
				key_pool[$urandom_range(47)] = k;
		end
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		int unsigned      r;
		logic [KEY_W-1:0] k;
		r = $urandom_range(99);
		k = KEY_W'($urandom);
		if (r < 45 && key_pool.size() != 0) begin
			k = key_pool[$urandom_range(key_pool.size() - 1)];
		end else if (r < 75) begin
			// crowd a few slots in both tables to force displacement chains
			if ($urandom_range(1))
				k = KEY_W'($urandom_range(7) * TABLE_SIZE * TABLE_SIZE);
			else
				k = KEY_W'(k - k % (TABLE_SIZE * TABLE_SIZE));
			k = KEY_W'(k + $urandom_range(7) * TABLE_SIZE + $urandom_range(7));
		end else if (r < 80) begin
			k = $urandom_range(1) ? '0 : '1;
		end
		return k;
	endfunction

	task automatic drain();
		@(negedge clk);
		while (request_q.size() != 0 || in_valid || awaited_outcomes.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_kicks(input logic [KICKS_W-1:0] v);
		drain();
		repeat (8) @(negedge clk);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		kick_limit = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [KICKS_W-1:0] seg_kicks [9];
		seg_kicks = '{7'd64, 7'd1, 7'd24, 7'd127, 7'd2, 7'd0, 7'd33, 7'd64, 7'd8};
		for (int i = 0; i < TABLE_SIZE; i++) begin
			row1_key[i] = '0;
			row1_used[i] = 1'b0;
			row2_key[i] = '0;
			row2_used[i] = 1'b0;
		end
		kick_limit = KICKS_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		push_req(1'b0, '0);
		push_req(1'b0, '1);
		push_req(1'b1, '0);
		push_req(1'b1, '0);
		push_req(1'b0, '0);
		push_req(1'b1, '1);
		push_req(1'b0, '1);
		push_req(1'b1, 31'd16);
		push_req(1'b0, '0);
		push_req(1'b0, 31'd16);

		// no kicks allowed: an absent key bounces straight back
		set_kicks(7'd0);
		push_req(1'b1, 31'd32);
		push_req(1'b0, 31'd32);

		// one round: the requested key lands while a displaced one is dropped
		set_kicks(7'd1);
		push_req(1'b1, 31'h100);
		push_req(1'b1, 31'h200);
		push_req(1'b0, 31'h200);
		push_req(1'b0, '0);

		// above the cap: behaves as 64 rounds
		set_kicks(7'd127);
		push_req(1'b1, '0);
		push_req(1'b0, '0);
		push_req(1'b1, 31'h5555_5555);
		push_req(1'b1, 31'h2AAA_AAAA);

		for (int s = 0; s < 9; s++) begin
			if (s == 3) begin
				send_idle = 47;
				recv_idle = 15;
			end else if (s == 6) begin
				send_idle = 0;
				recv_idle = 0;
			end
			set_kicks(seg_kicks[s]);
			for (int n = 0; n < 205; n++)
				push_req(logic'($urandom_range(1)), pick_key());
		end

		drain();
		repeat (300) @(posedge clk);
		if (mismatches == 0)
			$display("cuckoo_hash_set verification clean");
		else
			$display("cuckoo_hash_set verification failed");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/chs_pkg.sv
hw/rtl/chs_ram.sv
hw/rtl/chs_div.sv
hw/rtl/chs_dp.sv
hw/rtl/chs_ctrl.sv
hw/rtl/cuckoo_hash_set.sv
tb/sv/tb_cuckoo_hash_set.sv
